FILE: hw/rtl/vrp_pkg.sv
// shared constants, types and the sine table generator for the vertex rotate/project block
package vrp_pkg;

    // default number of quarter-wave sine table steps
    localparam int SINE_ENTRIES_DEFAULT = 1024;

    // one quarter turn in phase units
    localparam logic [14:0] PHASE_QUARTER = 15'd16384;

    // q30 taylor coefficients of sin(pi/2 * x)
    localparam logic [63:0] COEF_A1 = 64'd1686629713;
    localparam logic [63:0] COEF_A3 = 64'd693598669;
    localparam logic [63:0] COEF_A5 = 64'd85569306;
    localparam logic [63:0] COEF_A7 = 64'd5026994;
    localparam logic [63:0] COEF_A9 = 64'd172273;
    localparam logic [63:0] SINE_UNITY = 64'd16384;
    localparam logic [63:0] SINE_ROUND = 64'd32768;

    // register map: word select bit of paddr
    localparam int APB_ADDR_W = 3;
    localparam logic REG_ORIGIN_X = 1'b0;
    localparam logic REG_ORIGIN_Y = 1'b1;
    localparam logic [15:0] ORIGIN_X_RESET = 16'd8192;
    localparam logic [15:0] ORIGIN_Y_RESET = 16'd4096;

    // datapath widths
    localparam int X1_W = 19;
    localparam int Y2_W = 22;
    localparam int SUM_W = 24;
    localparam int OUT_W = 18;
    localparam logic signed [SUM_W-1:0] OUT_MAX = 24'sd131071;
    localparam logic signed [SUM_W-1:0] OUT_MIN = -24'sd131072;

    // unsigned q1.14 sine magnitude, 0..16384
    typedef logic [14:0] sine_mag_t;

    // signed q2.14 sine and cosine of one angle
    typedef struct packed {
        logic signed [15:0] sin_v;
        logic signed [15:0] cos_v;
    } sincos_t;

    // table word for scaled argument x (q30 fraction of a quarter turn)
    function automatic sine_mag_t sine_poly(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        t  = COEF_A9;
        t  = COEF_A7 - ((t * x2) >> 30);
        t  = COEF_A5 - ((t * x2) >> 30);
        t  = COEF_A3 - ((t * x2) >> 30);
        t  = COEF_A1 - ((t * x2) >> 30);
        s  = (t * x) >> 30;
        s  = (s + SINE_ROUND) >> 16;
        if (s > SINE_UNITY) begin
            s = SINE_UNITY;
        end
        return s[14:0];
    endfunction

endpackage

FILE: hw/rtl/vrp_sine_rom.sv
// quarter-wave sine rom with two registered read ports
module vrp_sine_rom #(
    parameter int SINE_TABLE_ENTRIES = vrp_pkg::SINE_ENTRIES_DEFAULT,
    localparam int IDX_W = $clog2(SINE_TABLE_ENTRIES + 1)
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [IDX_W-1:0]    addr_a,
    input  logic [IDX_W-1:0]    addr_b,
    output vrp_pkg::sine_mag_t  data_a,
    output vrp_pkg::sine_mag_t  data_b
);
    import vrp_pkg::*;

    sine_mag_t rom_c [SINE_TABLE_ENTRIES+1];
    sine_mag_t data_a_reg;
    sine_mag_t data_b_reg;

    // table contents fixed at elaboration
    for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] X_K = (64'(k) << 30) / SINE_TABLE_ENTRIES;
        assign rom_c[k] = sine_poly(X_K);
    end

    // registered reads
    always_ff @(posedge aclk) begin
        if (en) begin
            data_a_reg <= rom_c[addr_a];
            data_b_reg <= rom_c[addr_b];
        end
    end

    assign data_a = data_a_reg;
    assign data_b = data_b_reg;

endmodule

FILE: hw/rtl/vrp_sine_lookup.sv
// phase to signed sine and cosine, two register stages
module vrp_sine_lookup #(
    parameter int SINE_TABLE_ENTRIES = vrp_pkg::SINE_ENTRIES_DEFAULT
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [15:0]      phase,
    output vrp_pkg::sincos_t sc
);
    import vrp_pkg::*;

    localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
    localparam int PROD_W = 15 + IDX_W;

    logic [1:0]        quad_sin;
    logic [1:0]        quad_cos;
    logic [14:0]       r_sin;
    logic [14:0]       r_cos;
    logic [PROD_W-1:0] prod_sin;
    logic [PROD_W-1:0] prod_cos;
    logic [IDX_W-1:0]  idx_sin_reg;
    logic [IDX_W-1:0]  idx_cos_reg;
    logic              neg_sin_reg;
    logic              neg_cos_reg;
    logic              neg_sin_d_reg;
    logic              neg_cos_d_reg;
    sine_mag_t         mag_sin;
    sine_mag_t         mag_cos;
    logic signed [15:0] pos_sin;
    logic signed [15:0] pos_cos;

    // quadrant fold, cosine is sine a quarter turn ahead
    assign quad_sin = phase[15:14];
    assign quad_cos = quad_sin + 2'd1;
    assign r_sin = quad_sin[0] ? (PHASE_QUARTER - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
    assign r_cos = quad_cos[0] ? (PHASE_QUARTER - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};

    // scale folded phase to a table index
    assign prod_sin = PROD_W'(r_sin) * PROD_W'(SINE_TABLE_ENTRIES);
    assign prod_cos = PROD_W'(r_cos) * PROD_W'(SINE_TABLE_ENTRIES);

    always_ff @(posedge aclk) begin
        if (en) begin
            idx_sin_reg   <= prod_sin[14 +: IDX_W];
            idx_cos_reg   <= prod_cos[14 +: IDX_W];
            neg_sin_reg   <= quad_sin[1];
            neg_cos_reg   <= quad_cos[1];
            neg_sin_d_reg <= neg_sin_reg;
            neg_cos_d_reg <= neg_cos_reg;
        end
    end

    vrp_sine_rom #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_rom (
        .aclk   (aclk),
        .en     (en),
        .addr_a (idx_sin_reg),
        .addr_b (idx_cos_reg),
        .data_a (mag_sin),
        .data_b (mag_cos)
    );

    // apply quadrant sign
    assign pos_sin = $signed({1'b0, mag_sin});
    assign pos_cos = $signed({1'b0, mag_cos});
    assign sc.sin_v = neg_sin_d_reg ? -pos_sin : pos_sin;
    assign sc.cos_v = neg_cos_d_reg ? -pos_cos : pos_cos;

endmodule

FILE: hw/rtl/vrp_rotate.sv
// yaw then pitch rotation, four register stages
module vrp_rotate (
    input  logic                              aclk,
    input  logic                              en,
    input  logic signed [15:0]                vertex_x,
    input  logic signed [15:0]                vertex_y,
    input  logic signed [15:0]                vertex_z,
    input  vrp_pkg::sincos_t                  yaw,
    input  vrp_pkg::sincos_t                  pitch,
    output logic signed [vrp_pkg::X1_W-1:0]   x1,
    output logic signed [vrp_pkg::Y2_W-1:0]   y2
);
    import vrp_pkg::*;

    logic signed [31:0]     p_xc_reg;
    logic signed [31:0]     p_zs_reg;
    logic signed [31:0]     p_xs_reg;
    logic signed [31:0]     p_zc_reg;
    logic signed [15:0]     vy_a_reg;
    logic signed [15:0]     vy_b_reg;
    sincos_t                pitch_a_reg;
    sincos_t                pitch_b_reg;
    logic signed [32:0]     sum_x;
    logic signed [32:0]     sum_z;
    logic signed [X1_W-1:0] x1_b_reg;
    logic signed [X1_W-1:0] x1_c_reg;
    logic signed [X1_W-1:0] x1_d_reg;
    logic signed [X1_W-1:0] z1_b_reg;
    logic signed [31:0]     p_yc_reg;
    logic signed [34:0]     p_zp_reg;
    logic signed [35:0]     sum_y;
    logic signed [Y2_W-1:0] y2_d_reg;

    // rounded sums of the yaw and pitch products, 14 fraction bits (q19.14 for x and z, q22.14 for y)
    assign sum_x = 33'(p_xc_reg) + 33'(p_zs_reg) + 33'sd8192;
    assign sum_z = 33'(p_zc_reg) - 33'(p_xs_reg) + 33'sd8192;
    assign sum_y = 36'(p_yc_reg) - 36'(p_zp_reg) + 36'sd8192;

    always_ff @(posedge aclk) begin
        if (en) begin
            // yaw products
            p_xc_reg    <= 32'(vertex_x) * 32'(yaw.cos_v);
            p_zs_reg    <= 32'(vertex_z) * 32'(yaw.sin_v);
            p_xs_reg    <= 32'(vertex_x) * 32'(yaw.sin_v);
            p_zc_reg    <= 32'(vertex_z) * 32'(yaw.cos_v);
            vy_a_reg    <= vertex_y;
            pitch_a_reg <= pitch;
            // yaw sums
            x1_b_reg    <= sum_x[32:14];
            z1_b_reg    <= sum_z[32:14];
            vy_b_reg    <= vy_a_reg;
            pitch_b_reg <= pitch_a_reg;
            // pitch products
            p_yc_reg    <= 32'(vy_b_reg) * 32'(pitch_b_reg.cos_v);
            p_zp_reg    <= 35'(z1_b_reg) * 35'(pitch_b_reg.sin_v);
            x1_c_reg    <= x1_b_reg;
            // pitch sum
            y2_d_reg    <= sum_y[35:14];
            x1_d_reg    <= x1_c_reg;
        end
    end

    assign x1 = x1_d_reg;
    assign y2 = y2_d_reg;

endmodule

FILE: hw/rtl/vertex_rotate_project_core.sv
// top level: vertex rotate and orthographic project stream core with apb origin registers
//
// Takes one vertex beat per cycle while the output is not stalled and returns one screen
// point per vertex, in order. The pipeline runs through the input register, table index,
// table read (two read ports per angle, each table holds SINE_TABLE_ENTRIES+1 words), yaw
// products, yaw sums, pitch products, pitch sum, and the origin add with saturation. A
// stall on the output side freezes the whole pipeline; s_tready stays high whenever the
// output register is empty or being taken.
// Origin registers should be written only while no vertex is in flight.
module vertex_rotate_project_core #(
    parameter int SINE_TABLE_ENTRIES = vrp_pkg::SINE_ENTRIES_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // apb configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vrp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    // vertex input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // vertex_x, vertex_y, vertex_z, yaw_phase, pitch_phase (16 bits each)
    input  logic [79:0]                    s_tdata,
    // screen point output stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // screen_x [17:0], screen_y [35:18], zero [39:36]
    output logic [39:0]                    m_tdata
);
    import vrp_pkg::*;

    logic                     en;
    logic [15:0]              origin_x_reg;
    logic [15:0]              origin_y_reg;
    logic [6:0]               valid_reg;
    logic                     m_tvalid_reg;
    logic signed [15:0]       vx1_reg;
    logic signed [15:0]       vy1_reg;
    logic signed [15:0]       vz1_reg;
    logic [15:0]              yaw1_reg;
    logic [15:0]              pitch1_reg;
    logic signed [15:0]       vx2_reg;
    logic signed [15:0]       vy2_reg;
    logic signed [15:0]       vz2_reg;
    logic signed [15:0]       vx3_reg;
    logic signed [15:0]       vy3_reg;
    logic signed [15:0]       vz3_reg;
    sincos_t                  yaw_sc;
    sincos_t                  pitch_sc;
    logic signed [X1_W-1:0]   x1;
    logic signed [Y2_W-1:0]   y2;
    logic signed [SUM_W-1:0]  sum_x;
    logic signed [SUM_W-1:0]  sum_y;
    logic [OUT_W-1:0]         screen_x_next;
    logic [OUT_W-1:0]         screen_y_next;
    logic [OUT_W-1:0]         screen_x_reg;
    logic [OUT_W-1:0]         screen_y_reg;

    // pipeline advances unless a finished point is held
    assign en       = ~m_tvalid_reg | m_tready;
    assign s_tready = en;

    // apb register writes
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= ORIGIN_X_RESET;
            origin_y_reg <= ORIGIN_Y_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_ORIGIN_X: origin_x_reg <= pwdata[15:0];
                REG_ORIGIN_Y: origin_y_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // apb register reads
    always_comb begin
        unique case (paddr[2])
            REG_ORIGIN_X: prdata = {16'd0, origin_x_reg};
            REG_ORIGIN_Y: prdata = {16'd0, origin_y_reg};
            default:      prdata = 32'd0;
        endcase
    end

    // valid bits alongside the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            valid_reg    <= {valid_reg[5:0], s_tvalid};
            m_tvalid_reg <= valid_reg[6];
        end
    end

    // input register and vertex delay to line up with the table outputs
    always_ff @(posedge aclk) begin
        if (en) begin
            vx1_reg    <= $signed(s_tdata[15:0]);
            vy1_reg    <= $signed(s_tdata[31:16]);
            vz1_reg    <= $signed(s_tdata[47:32]);
            yaw1_reg   <= s_tdata[63:48];
            pitch1_reg <= s_tdata[79:64];
            vx2_reg    <= vx1_reg;
            vy2_reg    <= vy1_reg;
            vz2_reg    <= vz1_reg;
            vx3_reg    <= vx2_reg;
            vy3_reg    <= vy2_reg;
            vz3_reg    <= vz2_reg;
        end
    end

    vrp_sine_lookup #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_yaw_lookup (
        .aclk  (aclk),
        .en    (en),
        .phase (yaw1_reg),
        .sc    (yaw_sc)
    );

    vrp_sine_lookup #(
        .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
    ) u_pitch_lookup (
        .aclk  (aclk),
        .en    (en),
        .phase (pitch1_reg),
        .sc    (pitch_sc)
    );

    vrp_rotate u_rotate (
        .aclk     (aclk),
        .en       (en),
        .vertex_x (vx3_reg),
        .vertex_y (vy3_reg),
        .vertex_z (vz3_reg),
        .yaw      (yaw_sc),
        .pitch    (pitch_sc),
        .x1       (x1),
        .y2       (y2)
    );

    // projection onto the screen with saturation
    assign sum_x = $signed({8'd0, origin_x_reg}) + SUM_W'(x1);
    assign sum_y = $signed({8'd0, origin_y_reg}) - SUM_W'(y2);

    always_comb begin
        if (sum_x > OUT_MAX) begin
            screen_x_next = OUT_MAX[OUT_W-1:0];
        end else if (sum_x < OUT_MIN) begin
            screen_x_next = OUT_MIN[OUT_W-1:0];
        end else begin
            screen_x_next = sum_x[OUT_W-1:0];
        end
        if (sum_y > OUT_MAX) begin
            screen_y_next = OUT_MAX[OUT_W-1:0];
        end else if (sum_y < OUT_MIN) begin
            screen_y_next = OUT_MIN[OUT_W-1:0];
        end else begin
            screen_y_next = sum_y[OUT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            screen_x_reg <= screen_x_next;
            screen_y_reg <= screen_y_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, screen_y_reg, screen_x_reg};

endmodule
